### sv/vst_pkg.sv
// vst_pkg: shared widths, constants and register indexes of the speed trap
// no dependencies; used by the channel interfaces and the top level

package vst_pkg;

  // field widths of the channels
  localparam int SLOT_W      = 6;
  localparam int POS_W       = 12;
  localparam int FRAME_IN_W  = 16;
  localparam int PPM_W       = 16;
  localparam int FPS_W       = 8;
  localparam int SPEED_W     = 16;

  // default sizing
  localparam int SLOTS_DEF      = 64;
  localparam int FRAME_BITS_DEF = 16;

  // 3.6 km/h per m/s, times 16 for the output unit, times 256 for the q8 scale
  localparam int SCALE_W = 14;
  localparam logic [SCALE_W-1:0] SPEED_SCALE = 14'd14746;
  localparam logic [SPEED_W-1:0] SPEED_MAX   = 16'hFFFF;

  // numerator widths: distance, distance * fps, full numerator
  localparam int DIST_W     = POS_W + 1;
  localparam int NUM1_W     = DIST_W + FPS_W;
  localparam int NUM_W      = NUM1_W + SCALE_W;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_LINE_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LINE_X   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PPM_Q8       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FPS          = 8'd3;

  localparam logic [POS_W-1:0] START_LINE_RST = 12'd0;
  localparam logic [POS_W-1:0] END_LINE_RST   = 12'd0;
  localparam logic [PPM_W-1:0] PPM_RST        = 16'd256;
  localparam logic [FPS_W-1:0] FPS_RST        = 8'd30;

endpackage

### sv/vst_if.sv
// vst_if: valid/ready channel interfaces of the speed trap (input, result, config)
// depends on vst_pkg for field widths

interface vst_in_if import vst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SLOT_W-1:0]     slot;
  logic                  track_live;
  logic                  heading_left;
  logic [POS_W-1:0]      box_left;
  logic [POS_W-1:0]      box_width;
  logic [FRAME_IN_W-1:0] frame_number;

  modport source (
    output valid, slot, track_live, heading_left, box_left, box_width, frame_number,
    input  ready
  );
  modport sink (
    input  valid, slot, track_live, heading_left, box_left, box_width, frame_number,
    output ready
  );
endinterface

interface vst_out_if import vst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  done_slot;
  logic [SPEED_W-1:0] speed_sixteenths_kmh;
  logic               speed_saturated;

  modport source (
    output valid, done_slot, speed_sixteenths_kmh, speed_saturated,
    input  ready
  );
  modport sink (
    input  valid, done_slot, speed_sixteenths_kmh, speed_saturated,
    output ready
  );
endinterface

interface vst_cfg_if import vst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/vst_ram.sv
// vst_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module vst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/vehicle_speed_trap.sv
// vehicle_speed_trap: per-slot speed trap between two calibration lines
// depends on vst_pkg, vst_if (channel interfaces) and vst_ram

// Each request names one tracked object by slot. A live object that reaches its
// entry line (start line when heading left, end line when heading right) has its
// frame number and left edge recorded; when it reaches its exit line one result
// is returned with speed = |right edge - entry left| * fps * 14746 /
// (pixels_per_meter_q8 * elapsed frames) in 1/16 km/h, forced to 65535 with the
// saturated flag when elapsed frames or scale is zero or the quotient exceeds
// 16 bits. A request that is ignored (not live, slot out of range) leaves the
// block idle, one that gives no result is only evaluated, and one that gives a
// result also passes a single shared multiplier used three times in a row and
// a radix-2 divider (skipped when the divisor is zero) that retires one of 35
// quotient bits per cycle. A result waits in an output register, and the next
// request is taken while it waits. After reset a clearing pass wipes the slot
// activity table; no request is taken during it, configuration writes are.
// Configuration is expected to change only while the block is idle.

module vehicle_speed_trap import vst_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  vst_cfg_if.sink  cfg_chan,
  vst_in_if.sink   in_chan,
  vst_out_if.source out_chan
);

  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int DEN_W   = PPM_W + FRAME_BITS;
  localparam int MUL_BW  = (FRAME_BITS > SCALE_W) ? FRAME_BITS : SCALE_W;
  localparam int PROD_W  = NUM1_W + MUL_BW;
  localparam int ENTRY_W = POS_W + FRAME_BITS;

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_EVAL     = 8'b0000_0100,
    ST_MUL_DEN  = 8'b0000_1000,
    ST_MUL_NUM1 = 8'b0001_0000,
    ST_MUL_NUM2 = 8'b0010_0000,
    ST_DIV      = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [POS_W-1:0] start_line_r;
  logic [POS_W-1:0] end_line_r;
  logic [PPM_W-1:0] ppm_r;
  logic [FPS_W-1:0] fps_r;

  // captured request
  logic [SLOT_W-1:0]     slot_r;
  logic                  left_r;
  logic [POS_W-1:0]      bx_r;
  logic [POS_W-1:0]      bw_r;
  logic [FRAME_BITS-1:0] frame_r;

  // arithmetic
  logic [DIST_W-1:0]     dist_r;
  logic [FRAME_BITS-1:0] elapsed_r;
  logic [DEN_W-1:0]      den_r;
  logic [DEN_W-1:0]      rem_r;
  logic [NUM_W-1:0]      quo_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;

  // clearing pass
  logic [SLOT_AW-1:0] clr_idx_r;

  // result register
  logic               out_valid_r;
  logic [SLOT_W-1:0]  done_slot_r;
  logic [SPEED_W-1:0] speed_r;
  logic               sat_r;

  // table rams
  logic               act_wr_en;
  logic [SLOT_AW-1:0] act_wr_addr;
  logic               act_wr_data;
  logic               act_rd;
  logic               ent_wr_en;
  logic [ENTRY_W-1:0] ent_rd;
  logic               rd_en;
  logic [SLOT_AW-1:0] rd_addr;
  logic [SLOT_AW-1:0] slot_addr;

  // request handshake
  logic in_accept;
  logic in_take;
  logic cfg_accept;

  assign in_chan.ready  = state_r[1];  // ST_IDLE bit
  assign in_accept      = in_chan.valid & in_chan.ready;
  assign in_take        = in_accept & in_chan.track_live
                        & (32'(in_chan.slot) < 32'(SLOTS));
  assign cfg_chan.ready = 1'b1;
  assign cfg_accept     = cfg_chan.valid & cfg_chan.ready;

  assign rd_en     = in_take;
  assign rd_addr   = SLOT_AW'(in_chan.slot);
  assign slot_addr = SLOT_AW'(slot_r);

  // ---------------------------------------------------------------------------
  // entry / exit decision, evaluated the cycle after the table read
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0]     right_edge;
  logic                  entering;
  logic                  leaving;
  logic                  ent_set;
  logic                  act_mid;
  logic [POS_W-1:0]      pos_eff;
  logic [FRAME_BITS-1:0] frame_eff;
  logic                  finish;

  assign right_edge = DIST_W'(bx_r) + DIST_W'(bw_r);
  assign entering   = left_r ? (bx_r >= start_line_r) : (bx_r <= end_line_r);
  assign leaving    = left_r ? (right_edge <= DIST_W'(end_line_r)) : (bx_r >= start_line_r);
  // slot not yet timing and entry line reached: timing starts in this request
  assign ent_set    = ~act_rd & entering;
  assign act_mid    = act_rd | ent_set;
  assign pos_eff    = ent_set ? bx_r : ent_rd[FRAME_BITS +: POS_W];
  assign frame_eff  = ent_set ? frame_r : ent_rd[FRAME_BITS-1:0];
  assign finish     = act_mid & leaving;

  // activity table: cleared by the sweep, rewritten once per evaluated request
  always_comb begin
    act_wr_en   = 1'b0;
    act_wr_addr = slot_addr;
    act_wr_data = 1'b0;
    if (state_r == ST_CLEAR) begin
      act_wr_en   = 1'b1;
      act_wr_addr = clr_idx_r;
    end else if (state_r == ST_EVAL) begin
      act_wr_en   = 1'b1;
      act_wr_data = act_mid & ~leaving;
    end
  end

  assign ent_wr_en = (state_r == ST_EVAL) & ent_set;

  vst_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_act_ram (
    .clk     (clk),
    .wr_en   (act_wr_en),
    .wr_addr (act_wr_addr),
    .wr_data (act_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (act_rd)
  );

  // entry left edge and frame, written only when timing starts
  vst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (slot_addr),
    .wr_data ({bx_r, frame_r}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ent_rd)
  );

  // ---------------------------------------------------------------------------
  // shared multiplier: denominator, then distance * fps, then * scale
  // ---------------------------------------------------------------------------
  logic [NUM1_W-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;

  always_comb begin
    case (state_r)
      ST_MUL_DEN: begin
        mul_a = NUM1_W'(ppm_r);
        mul_b = MUL_BW'(elapsed_r);
      end
      ST_MUL_NUM1: begin
        mul_a = NUM1_W'(dist_r);
        mul_b = MUL_BW'(fps_r);
      end
      ST_MUL_NUM2: begin
        mul_a = quo_r[NUM1_W-1:0];
        mul_b = MUL_BW'(SPEED_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // ---------------------------------------------------------------------------
  // restoring divider step: one quotient bit per cycle
  // ---------------------------------------------------------------------------
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             q_bit;
  logic             den_zero;
  logic             quo_over;

  assign trial    = {rem_r, quo_r[NUM_W-1]};
  assign diff     = trial - {1'b0, den_r};
  assign q_bit    = ~diff[DEN_W];
  assign den_zero = (den_r == '0);
  assign quo_over = |quo_r[NUM_W-1:SPEED_W];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic out_load;

  assign out_load = (state_r == ST_DONE) & (~out_valid_r | out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == SLOT_AW'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = finish ? ST_MUL_DEN : ST_IDLE;
      end
      ST_MUL_DEN: begin
        state_nxt = ST_MUL_NUM1;
      end
      ST_MUL_NUM1: begin
        state_nxt = ST_MUL_NUM2;
      end
      ST_MUL_NUM2: begin
        // zero divisor saturates without dividing
        state_nxt = den_zero ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_line_r <= START_LINE_RST;
      end_line_r   <= END_LINE_RST;
      ppm_r        <= PPM_RST;
      fps_r        <= FPS_RST;
    end else if (cfg_accept) begin
      unique case (cfg_chan.index)
        CFG_START_LINE_X: start_line_r <= cfg_chan.data[POS_W-1:0];
        CFG_END_LINE_X:   end_line_r   <= cfg_chan.data[POS_W-1:0];
        CFG_PPM_Q8:       ppm_r        <= cfg_chan.data[PPM_W-1:0];
        CFG_FPS:          fps_r        <= cfg_chan.data[FPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      slot_r  <= in_chan.slot;
      left_r  <= in_chan.heading_left;
      bx_r    <= in_chan.box_left;
      bw_r    <= in_chan.box_width;
      frame_r <= FRAME_BITS'(in_chan.frame_number);
    end

    if (state_r == ST_EVAL) begin
      dist_r    <= (right_edge >= DIST_W'(pos_eff)) ? right_edge - DIST_W'(pos_eff)
                                                    : DIST_W'(pos_eff) - right_edge;
      elapsed_r <= frame_r - frame_eff;  // wraps modulo the frame counter
    end

    if (state_r == ST_MUL_DEN) begin
      den_r <= mul_p[DEN_W-1:0];
    end

    if ((state_r == ST_MUL_NUM1) || (state_r == ST_MUL_NUM2)) begin
      quo_r <= mul_p[NUM_W-1:0];
    end else if (state_r == ST_DIV) begin
      quo_r <= {quo_r[NUM_W-2:0], q_bit};
    end

    if (state_r == ST_MUL_NUM2) begin
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r     <= q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      div_cnt_r <= div_cnt_r + 1'b1;
    end

    if (out_load) begin
      done_slot_r <= slot_r;
      sat_r       <= den_zero | quo_over;
      speed_r     <= (den_zero | quo_over) ? SPEED_MAX : quo_r[SPEED_W-1:0];
    end
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.done_slot            = done_slot_r;
  assign out_chan.speed_sixteenths_kmh = speed_r;
  assign out_chan.speed_saturated      = sat_r;

endmodule

### tb/testbench.sv
// testbench: self-checking bench for the vehicle_speed_trap per-slot speed trap
// depends on vst_pkg, the channel interfaces in vst_if and the vehicle_speed_trap rtl
// a queue-fed driver, a result monitor and an in-bench predictor of the slot table
`timescale 1ns / 100ps

module testbench;
  import vst_pkg::*;

  // run limits, in clock cycles
  localparam int CYCLE_LIMIT       = 1000000;
  localparam int DRAIN_CYCLES      = 64;
  localparam int END_WAIT_LIMIT    = 5000;
  localparam int RECV_HOLD_AFTER   = 400;   // live requests accepted before the long hold
  localparam int RECV_HOLD_CYCLES  = 600;
  localparam int MAX_PRINTED       = 50;

  // one sighting of a tracked object, as carried by the input channel
  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic                  track_live;
    logic                  heading_left;
    logic [POS_W-1:0]      box_left;
    logic [POS_W-1:0]      box_width;
    logic [FRAME_IN_W-1:0] frame_number;
  } sighting_t;

  // one finished passage, as carried by the result channel
  typedef struct packed {
    logic [SLOT_W-1:0]  done_slot;
    logic [SPEED_W-1:0] speed;
    logic               saturated;
  } speed_rec_t;

  // a synthetic vehicle crossing the region, used to build well-formed tracks
  typedef struct {
    logic [SLOT_W-1:0]     slot;
    logic                  heading_left;
    int                    x;
    int                    w;
    int                    dx;
    int                    steps;
    logic [FRAME_IN_W-1:0] frame;
  } car_t;

  logic clk = 1'b0;
  logic rst_n;

  vst_in_if  in_if ();
  vst_out_if out_if ();
  vst_cfg_if cfg_if ();

  vehicle_speed_trap #(
    .SLOTS      (SLOTS_DEF),
    .FRAME_BITS (FRAME_BITS_DEF)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_if),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #5 clk = ~clk;

  // mirror of the configuration registers, starting from their reset values
  logic [POS_W-1:0] start_line = START_LINE_RST;
  logic [POS_W-1:0] end_line   = END_LINE_RST;
  logic [PPM_W-1:0] ppm_q8     = PPM_RST;
  logic [FPS_W-1:0] fps        = FPS_RST;

  // mirror of the slot table; the entry fields only matter while timing is set
  bit                    slot_timing    [SLOTS_DEF];
  logic [FRAME_IN_W-1:0] entry_frame_of [SLOTS_DEF];
  logic [POS_W-1:0]      entry_x_of     [SLOTS_DEF];

  sighting_t  pending_sightings [$];   // requests waiting for the driver
  speed_rec_t pending_speeds    [$];   // speeds the block still owes us

  sighting_t on_offer;
  bit        in_holding = 1'b0;        // a request is on the channel, not yet taken
  int        send_gap   = 0;
  int        take_gap   = 0;
  bit        steady     = 1'b0;        // no idling on either side while set
  bit        recv_hold  = 1'b0;        // receiver holds off for a long stretch
  int        live_sent  = 0;
  int        mismatches = 0;
  int        cycle_count = 0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // update the slot table for one accepted sighting and queue the speed it causes
  function automatic void track_sighting(sighting_t s);
    logic [POS_W:0]        right_edge;
    logic [POS_W:0]        travel;
    logic [FRAME_IN_W-1:0] elapsed;
    longint unsigned       num;
    longint unsigned       den;
    longint unsigned       quo;
    bit                    entering;
    bit                    leaving;
    speed_rec_t            rec;
    if (!s.track_live) return;
    right_edge = {1'b0, s.box_left} + {1'b0, s.box_width};

    // entry first: start line when heading left, end line when heading right
    entering = s.heading_left ? (s.box_left >= start_line) : (s.box_left <= end_line);
    if (!slot_timing[s.slot] && entering) begin
      slot_timing[s.slot]    = 1'b1;
      entry_frame_of[s.slot] = s.frame_number;
      entry_x_of[s.slot]     = s.box_left;
    end

    // exit may follow in the same request, which leaves zero elapsed frames
    leaving = s.heading_left ? (right_edge <= {1'b0, end_line}) : (s.box_left >= start_line);
    if (slot_timing[s.slot] && leaving) begin
      travel = (right_edge >= {1'b0, entry_x_of[s.slot]})
             ? right_edge - {1'b0, entry_x_of[s.slot]}
             : {1'b0, entry_x_of[s.slot]} - right_edge;
      elapsed = s.frame_number - entry_frame_of[s.slot];
      num = 64'(travel) * 64'(fps) * 64'(SPEED_SCALE);
      den = 64'(ppm_q8) * 64'(elapsed);
      rec.done_slot = s.slot;
      if (den == 0) begin
        // zero elapsed frames or zero pixel scale
        rec.speed     = SPEED_MAX;
        rec.saturated = 1'b1;
      end else begin
        quo = num / den;
        if (quo > 64'(SPEED_MAX)) begin
          rec.speed     = SPEED_MAX;
          rec.saturated = 1'b1;
        end else begin
          rec.speed     = quo[SPEED_W-1:0];
          rec.saturated = 1'b0;
        end
      end
      slot_timing[s.slot] = 1'b0;
      pending_speeds.insert(pending_speeds.size(), rec);
    end
  endfunction

  // driver: offers queued requests, predicts each one as it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_holding = 1'b0;
      send_gap   = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        track_sighting(on_offer);
        if (on_offer.track_live) live_sent++;
        in_holding = 1'b0;
        send_gap   = pick_gap();
      end
      // a request still waiting keeps valid and payload as they are
      if (!in_holding) begin
        if (send_gap > 0 || pending_sightings.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_if.valid <= 1'b0;
        end else begin
          on_offer   = pending_sightings.pop_front();
          in_holding = 1'b1;
          in_if.valid        <= 1'b1;
          in_if.slot         <= on_offer.slot;
          in_if.track_live   <= on_offer.track_live;
          in_if.heading_left <= on_offer.heading_left;
          in_if.box_left     <= on_offer.box_left;
          in_if.box_width    <= on_offer.box_width;
          in_if.frame_number <= on_offer.frame_number;
        end
      end
    end
  end

  // monitor: checks each taken result against the oldest predicted speed
  always @(posedge clk) begin
    speed_rec_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_speeds.size() == 0) begin
          flag_mismatch($sformatf("result for slot %0d with nothing pending",
                                  out_if.done_slot));
        end else begin
          want = pending_speeds.pop_front();
          if (out_if.done_slot !== want.done_slot)
            flag_mismatch($sformatf("done_slot %0d, want %0d",
                                    out_if.done_slot, want.done_slot));
          if (out_if.speed_sixteenths_kmh !== want.speed)
            flag_mismatch($sformatf("slot %0d: speed %0d, want %0d", want.done_slot,
                                    out_if.speed_sixteenths_kmh, want.speed));
          if (out_if.speed_saturated !== want.saturated)
            flag_mismatch($sformatf("slot %0d: saturated %0b, want %0b", want.done_slot,
                                    out_if.speed_saturated, want.saturated));
        end
      end
      if (recv_hold) begin
        out_if.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        out_if.ready <= 1'b0;
      end else begin
        take_gap = pick_gap();
        out_if.ready <= (take_gap == 0);
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps offering: the output register
  // fills and the block has to stall its input
  initial begin
    do @(negedge clk); while (live_sent < RECV_HOLD_AFTER);
    recv_hold = 1'b1;
    repeat (RECV_HOLD_CYCLES) @(negedge clk);
    recv_hold = 1'b0;
  end

  task automatic queue_sighting(input logic [SLOT_W-1:0] slot, input logic live,
                                input logic heading_left, input logic [POS_W-1:0] bx,
                                input logic [POS_W-1:0] bw,
                                input logic [FRAME_IN_W-1:0] frame);
    sighting_t s;
    s.slot         = slot;
    s.track_live   = live;
    s.heading_left = heading_left;
    s.box_left     = bx;
    s.box_width    = bw;
    s.frame_number = frame;
    pending_sightings.insert(pending_sightings.size(), s);
  endtask

  // one register write request; the mirror follows once it is taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_START_LINE_X: start_line = val[POS_W-1:0];
      CFG_END_LINE_X:   end_line   = val[POS_W-1:0];
      CFG_PPM_Q8:       ppm_q8     = val[PPM_W-1:0];
      CFG_FPS:          fps        = val[FPS_W-1:0];
      default: ;  // unknown index, ignored by the block
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // sender pauses until every owed speed has come, then the last request that
  // gave no result gets time to finish before the registers change
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_sightings.size() != 0 || in_holding || pending_speeds.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [POS_W-1:0] s_line, input logic [POS_W-1:0] e_line,
                            input logic [PPM_W-1:0] ppm, input logic [FPS_W-1:0] rate);
    wait_drained();
    // junk write to an unused index, must leave everything alone
    write_reg(CFG_IDX_W'($urandom_range(int'(CFG_FPS) + 1, 255)), CFG_DATA_W'($urandom));
    // unused upper data bits carry noise
    write_reg(CFG_START_LINE_X, {4'($urandom), s_line});
    write_reg(CFG_END_LINE_X,   {4'($urandom), e_line});
    write_reg(CFG_PPM_Q8,       ppm);
    write_reg(CFG_FPS,          {8'($urandom), rate});
  endtask

  // random traffic: several vehicles crossing the region at once, interleaved,
  // with some noise requests and dropped tracks mixed in
  task automatic run_traffic(input int live_items, input bit no_idle);
    car_t cars [$];
    car_t c;
    int   made;
    int   k;
    int   span;
    int   roll;
    int   step;
    bit   taken;
    bit   live;
    bit   done_now;
    steady = no_idle;
    made   = 0;
    while (made < live_items) begin
      if (cars.size() == 0 || (cars.size() < 6 && $urandom_range(0, 3) == 0)) begin
        c.heading_left = 1'($urandom_range(0, 1));
        do begin
          c.slot = SLOT_W'($urandom);
          taken  = 1'b0;
          foreach (cars[i]) if (cars[i].slot == c.slot) taken = 1'b1;
        end while (taken);
        k = $urandom_range(1, 6);
        if (c.heading_left) begin
          // starts at or past the start line, moves left until its right edge
          // is back over the end line
          c.x = int'(start_line) + int'($urandom_range(0, 300));
          if (c.x > 4095) c.x = 4095;
          c.w = $urandom_range(0, (end_line < 400) ? int'(end_line) : 400);
          span = c.x - (int'(end_line) - c.w);
        end else begin
          c.x = int'(end_line) - int'($urandom_range(0, 300));
          if (c.x < 0) c.x = 0;
          c.w = $urandom_range(0, 400);
          span = int'(start_line) - c.x;
        end
        if (span < 0) span = 0;
        c.dx    = span / k + 1;
        c.steps = 0;
        c.frame = FRAME_IN_W'($urandom);
        cars.insert(cars.size(), c);
      end

      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        live = ($urandom_range(0, 7) != 0);
        queue_sighting(SLOT_W'($urandom), live, 1'($urandom), POS_W'($urandom),
                       POS_W'($urandom), FRAME_IN_W'($urandom));
        if (live) made++;
      end else begin
        k = $urandom_range(0, cars.size() - 1);
        c = cars[k];
        // a rare dropout leaves the slot timing for a later vehicle
        live = ($urandom_range(0, 49) != 0);
        queue_sighting(c.slot, live, c.heading_left, POS_W'(c.x), POS_W'(c.w), c.frame);
        if (live) made++;
        c.steps++;
        done_now = c.heading_left ? (c.x + c.w <= int'(end_line)) : (c.x >= int'(start_line));
        if (done_now || c.steps >= 14) begin
          cars.delete(k);
        end else begin
          if (c.heading_left) c.x = (c.x > c.dx) ? c.x - c.dx : 0;
          else                c.x = (c.x + c.dx > 4095) ? 4095 : c.x + c.dx;
          // mostly a frame or three apart; sometimes none, sometimes a long gap
          roll = $urandom_range(0, 99);
          if (roll < 4)       step = 0;
          else if (roll < 90) step = $urandom_range(1, 3);
          else if (roll < 98) step = $urandom_range(4, 60);
          else                step = $urandom_range(0, 65535);
          c.frame = c.frame + FRAME_IN_W'(step);
          cars[k] = c;
        end
      end
    end
  endtask

  initial begin
    int guard;
    rst_n = 1'b0;
    in_if.valid        = 1'b0;
    in_if.slot         = '0;
    in_if.track_live   = 1'b0;
    in_if.heading_left = 1'b0;
    in_if.box_left     = '0;
    in_if.box_width    = '0;
    in_if.frame_number = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset configuration: both lines at 0
    // heading right at x 0 enters and exits at once, zero elapsed frames
    queue_sighting(6'd0, 1'b1, 1'b0, 12'd0, 12'd0, 16'd0);
    // not live, nothing happens
    queue_sighting(6'd63, 1'b0, 1'b1, 12'd4095, 12'd4095, 16'd65535);
    // widest box enters heading left, then exits across the frame wrap: overflow
    queue_sighting(6'd5, 1'b1, 1'b1, 12'd4095, 12'd4095, 16'd65535);
    queue_sighting(6'd5, 1'b1, 1'b1, 12'd0, 12'd0, 16'd2);

    // directed, finest scale and fastest frame rate
    set_config(12'd2000, 12'd600, 16'hFFFF, 8'hFF);
    queue_sighting(6'd10, 1'b1, 1'b1, 12'd2500, 12'd100, 16'd100);
    queue_sighting(6'd10, 1'b1, 1'b1, 12'd1200, 12'd100, 16'd101);
    // right edge exactly on the end line
    queue_sighting(6'd10, 1'b1, 1'b1, 12'd400, 12'd200, 16'd110);
    // heading right, entry exactly on the end line, exit exactly on the start line
    queue_sighting(6'd20, 1'b1, 1'b0, 12'd600, 12'd4095, 16'd65530);
    queue_sighting(6'd20, 1'b1, 1'b0, 12'd1999, 12'd0, 16'd65533);
    queue_sighting(6'd20, 1'b1, 1'b0, 12'd2000, 12'd0, 16'd4);
    // idle slot past the end line: no entry
    queue_sighting(6'd20, 1'b1, 1'b0, 12'd4095, 12'd4095, 16'd5);
    // timing slot, not live at the exit, then exit with the entry frame again
    queue_sighting(6'd33, 1'b1, 1'b1, 12'd2000, 12'd0, 16'd7);
    queue_sighting(6'd33, 1'b0, 1'b1, 12'd0, 12'd0, 16'd8);
    queue_sighting(6'd33, 1'b1, 1'b1, 12'd0, 12'd4095, 16'd9);
    queue_sighting(6'd33, 1'b1, 1'b1, 12'd0, 12'd600, 16'd7);

    // zero pixel scale saturates
    set_config(12'd2000, 12'd600, 16'd0, 8'd30);
    queue_sighting(6'd40, 1'b1, 1'b0, 12'd0, 12'd50, 16'd1000);
    queue_sighting(6'd40, 1'b1, 1'b0, 12'd2100, 12'd50, 16'd1003);

    // zero frame rate gives zero speed
    set_config(12'd2000, 12'd600, 16'd256, 8'd0);
    queue_sighting(6'd41, 1'b1, 1'b0, 12'd100, 12'd10, 16'd500);
    queue_sighting(6'd41, 1'b1, 1'b0, 12'd2100, 12'd10, 16'd520);

    // random traffic over several settings
    set_config(12'd3000, 12'd1000, 16'd5120, 8'd30);
    run_traffic(220, 1'b0);
    set_config(12'd4095, 12'd0, 16'd1, 8'd255);     // widest region, coarsest scale
    run_traffic(150, 1'b1);
    set_config(12'd1800, 12'd1700, 16'hFFFF, 8'd1); // narrow region, slowest rate
    run_traffic(150, 1'b0);
    set_config(12'd2500, 12'd500, 16'd0, 8'd30);
    run_traffic(60, 1'b0);
    set_config(12'd2500, 12'd500, 16'd2560, 8'd0);
    run_traffic(60, 1'b0);
    set_config(12'd500, 12'd2500, 16'd256, 8'd60);  // lines swapped
    run_traffic(120, 1'b0);
    set_config(12'd2048, 12'd1024, 16'd12800, 8'd25);
    run_traffic(250, 1'b0);

    // all stimulus taken, then wait for the last speeds
    do @(negedge clk); while (pending_sightings.size() != 0 || in_holding);
    guard = 0;
    while (pending_speeds.size() != 0 && guard < END_WAIT_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_speeds.size() != 0)
      flag_mismatch($sformatf("%0d speeds never arrived", pending_speeds.size()));
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
